// File: hw/rtl/window_pooling_max_avg_unit_defines.svh
// ----------------------------------------------------------------------------
// window pooling unit assertion macros
// shared property forms for the concurrent checks of the pooling unit
// ----------------------------------------------------------------------------
`ifndef WINDOW_POOLING_MAX_AVG_UNIT_DEFINES_SVH
`define WINDOW_POOLING_MAX_AVG_UNIT_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define WPMA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define WPMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/wpma_pkg.sv
// ----------------------------------------------------------------------------
// wpma_pkg
// shared widths, register indexes and controller/datapath bundles
// ----------------------------------------------------------------------------
package wpma_pkg;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int ACC_W      = 24;
  localparam int RECIP_W    = 16;
  localparam int K_W        = 4;
  localparam int DIM_W      = 9;
  localparam int ROW_W      = 8;
  localparam int COL_W      = 9;
  localparam int SUM_W      = 10;
  localparam int IDX_W      = 8;
  localparam int PROD_W     = ACC_W + RECIP_W + 1;
  localparam int FRAC_SHIFT = 15;
  localparam int Q_W        = PROD_W - FRAC_SHIFT;

  // configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP  = 3'd5;

  // register reset values
  localparam logic [K_W-1:0]     RST_KERNEL = 4'd2;
  localparam logic [K_W-1:0]     RST_STRIDE = 4'd2;
  localparam logic [DIM_W-1:0]   RST_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0]   RST_HEIGHT = 9'd256;
  localparam logic [RECIP_W-1:0] RST_RECIP  = 16'd8192;

  localparam int MAX_HEIGHT = 256;

  // saturation limits of the q8.8 result
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

  // effective pooling geometry after clamping
  typedef struct packed {
    logic [K_W-1:0]     k;
    logic [K_W-1:0]     s;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic               avg_mode;
    logic [RECIP_W-1:0] recip;
  } geom_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic rd;
    logic upd;
    logic mult;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_win;
    logic hit_any;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/wpma_sample_if.sv
// ----------------------------------------------------------------------------
// wpma_sample_if
// input channel: one q8.8 sample per item with valid/ready
// ----------------------------------------------------------------------------
interface wpma_sample_if;
  import wpma_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);

endinterface

// File: hw/rtl/wpma_result_if.sv
// ----------------------------------------------------------------------------
// wpma_result_if
// output channel: pooled value with its grid position and plane end flag
// ----------------------------------------------------------------------------
interface wpma_result_if;
  import wpma_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] pooled_value;
  logic [IDX_W-1:0]           pooled_row;
  logic [IDX_W-1:0]           pooled_col;
  logic                       plane_done;

  modport source (
    output valid, output pooled_value, output pooled_row, output pooled_col,
    output plane_done, input ready
  );
  modport sink (
    input valid, input pooled_value, input pooled_row, input pooled_col,
    input plane_done, output ready
  );

endinterface

// File: hw/rtl/window_pooling_max_avg_unit.sv
// Sequence: a sample is accepted only while idle, then each window it updates is a read
//   then a write of the accumulator ram; a sample that closes a window adds a scaling step
//   and an emit, which waits while the previous result is still held on the output.
//   No new sample is taken until the previous one is finished.
// Reset: synchronous active-high rst restores register defaults and plane start;
//   accumulator ram is not cleared, each window's first sample overwrites its entry.
// ----------------------------------------------------------------------------
// window_pooling_max_avg_unit
// 2-d max / average pooling over raster-order q8.8 planes
// ----------------------------------------------------------------------------
module window_pooling_max_avg_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_KERNEL = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [wpma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wpma_pkg::CFG_W-1:0]     cfg_data,
  wpma_sample_if.sink                    sample_ch,
  wpma_result_if.source                  result_ch
);
  import wpma_pkg::*;

  localparam int W_CAP = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
  localparam int K_CAP = (MAX_KERNEL < 15) ? MAX_KERNEL : 15;

  // configuration registers
  logic [K_W-1:0]     kernel_size;
  logic [K_W-1:0]     stride;
  logic [DIM_W-1:0]   plane_width;
  logic [DIM_W-1:0]   plane_height;
  logic               pool_mode;
  logic [RECIP_W-1:0] avg_reciprocal;
  logic               restart;

  // clamped geometry
  logic [DIM_W-1:0] eff_w, eff_h, kmax, kmax_wh;
  logic [K_W-1:0]   eff_k, eff_s;
  geom_t            geom;

  cmd_t cmd;
  sts_t sts;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_size    <= RST_KERNEL;
      stride         <= RST_STRIDE;
      plane_width    <= RST_WIDTH;
      plane_height   <= RST_HEIGHT;
      pool_mode      <= 1'b0;
      avg_reciprocal <= RST_RECIP;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KERNEL: kernel_size    <= cfg_data[K_W-1:0];
        REG_STRIDE: stride         <= cfg_data[K_W-1:0];
        REG_WIDTH:  plane_width    <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: plane_height   <= cfg_data[DIM_W-1:0];
        REG_MODE:   pool_mode      <= cfg_data[0];
        REG_RECIP:  avg_reciprocal <= cfg_data[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // any write to a known register restarts the plane
  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_KERNEL, REG_STRIDE, REG_WIDTH,
        REG_HEIGHT, REG_MODE, REG_RECIP: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  // plane size clamped to the supported range
  always_comb begin
    if (plane_width == '0) begin
      eff_w = DIM_W'(1);
    end else if (plane_width > DIM_W'(W_CAP)) begin
      eff_w = DIM_W'(W_CAP);
    end else begin
      eff_w = plane_width;
    end
    if (plane_height == '0) begin
      eff_h = DIM_W'(1);
    end else if (plane_height > DIM_W'(MAX_HEIGHT)) begin
      eff_h = DIM_W'(MAX_HEIGHT);
    end else begin
      eff_h = plane_height;
    end
  end

  // kernel limited by storage and plane, stride limited by kernel
  always_comb begin
    kmax_wh = (eff_w < eff_h) ? eff_w : eff_h;
    kmax    = (DIM_W'(K_CAP) < kmax_wh) ? DIM_W'(K_CAP) : kmax_wh;
    if (kernel_size == '0) begin
      eff_k = K_W'(1);
    end else if (DIM_W'(kernel_size) > kmax) begin
      eff_k = kmax[K_W-1:0];
    end else begin
      eff_k = kernel_size;
    end
    if (stride == '0) begin
      eff_s = K_W'(1);
    end else if (stride > eff_k) begin
      eff_s = eff_k;
    end else begin
      eff_s = stride;
    end
  end

  assign geom.k        = eff_k;
  assign geom.s        = eff_s;
  assign geom.width    = eff_w;
  assign geom.height   = eff_h;
  assign geom.avg_mode = pool_mode;
  assign geom.recip    = avg_reciprocal;

  // sequencer
  wpma_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_ch.valid),
    .sample_ready (sample_ch.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // datapath
  wpma_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .restart   (restart),
    .cmd       (cmd),
    .sts       (sts),
    .sample    (sample_ch.sample),
    .result_ch (result_ch)
  );

endmodule

// File: hw/rtl/wpma_ram.sv
// ----------------------------------------------------------------------------
// wpma_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module wpma_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/wpma_ctrl.sv
// ----------------------------------------------------------------------------
// wpma_ctrl
// sequencer: walks the windows touched by one sample, then, if one closed, scales and emits
// ----------------------------------------------------------------------------
`include "window_pooling_max_avg_unit_defines.svh"

module wpma_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          sample_valid,
  output logic          sample_ready,
  input  wpma_pkg::sts_t sts,
  output wpma_pkg::cmd_t cmd
);
  import wpma_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_MULT   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    sample_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.upd = 1'b1;
        if (sts.last_win) begin
          state_next = sts.hit_any ? ST_MULT : ST_IDLE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // checks
  `WPMA_ASSERT_NEXT(a_read_then_update, clk, rst, state == ST_READ, state == ST_UPDATE, "read not followed by update")
  `WPMA_ASSERT_NOW(a_mult_needs_hit, clk, rst, state == ST_MULT, sts.hit, "scaling without a finished window")
  `WPMA_ASSERT_NEXT(a_emit_waits, clk, rst, state == ST_EMIT && !sts.out_free, state == ST_EMIT, "emit left while output full")

endmodule

// File: hw/rtl/wpma_dp.sv
// ----------------------------------------------------------------------------
// wpma_dp
// position trackers, window loop counters, accumulator ram, scaler, output reg
// ----------------------------------------------------------------------------
module wpma_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_KERNEL = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  wpma_pkg::geom_t                    geom,
  input  logic                               restart,
  input  wpma_pkg::cmd_t                     cmd,
  output wpma_pkg::sts_t                     sts,
  input  logic signed [wpma_pkg::SAMPLE_W-1:0] sample,
  wpma_result_if.source                      result_ch
);
  import wpma_pkg::*;

  localparam int DEPTH     = MAX_KERNEL * MAX_WIDTH;
  localparam int AW        = $clog2(DEPTH);
  localparam int SLOT_W    = $clog2(MAX_KERNEL);
  localparam int LAST_SLOT = MAX_KERNEL - 1;

  // geometry in sum width
  logic [SUM_W-1:0] k10, s10, w10, h10;

  // plane position and the window ranges that contain it
  logic [ROW_W-1:0]  h, h_next;
  logic [COL_W-1:0]  w, w_next;
  logic [ROW_W-1:0]  pr_lo, pr_lo_next, prs_lo, prs_lo_next;
  logic [ROW_W-1:0]  pr_hi, pr_hi_next, prs_hi, prs_hi_next;
  logic [SLOT_W-1:0] pslot_lo, pslot_lo_next;
  logic [COL_W-1:0]  pc_lo, pc_lo_next, pcs_lo, pcs_lo_next;
  logic [COL_W-1:0]  pc_hi, pc_hi_next, pcs_hi, pcs_hi_next;
  logic [SUM_W-1:0]  h_inc, w_inc;

  // window loop of the current item
  logic signed [SAMPLE_W-1:0] x;
  logic [ROW_W-1:0]  lh;
  logic [COL_W-1:0]  lw;
  logic [ROW_W-1:0]  cr, crs, cr_hi;
  logic [SLOT_W-1:0] cslot;
  logic [COL_W-1:0]  cc, ccs, cc_lo, ccs_lo, cc_hi;

  // accumulator access
  logic [AW-1:0]           addr;
  logic [ACC_W-1:0]        rd_data;
  logic signed [ACC_W-1:0] acc_rd, x_ext, acc_new;
  logic                    first, row_end, col_end, end_now, last_grid;
  logic [SUM_W-1:0]        crs_k, ccs_k, lh_inc, lw_inc;

  // finished window and scaling
  logic                       hit;
  logic signed [ACC_W-1:0]    fin_val;
  logic [ROW_W-1:0]           fin_r;
  logic [COL_W-1:0]           fin_c;
  logic                       fin_done;
  logic signed [PROD_W-1:0]   prod;
  logic signed [Q_W-1:0]      q;
  logic                       q_ovf;
  logic signed [SAMPLE_W-1:0] avg_val, res_val;

  // output register
  logic out_valid;

  assign k10 = SUM_W'(geom.k);
  assign s10 = SUM_W'(geom.s);
  assign w10 = SUM_W'(geom.width);
  assign h10 = SUM_W'(geom.height);

  assign h_inc = SUM_W'(h) + SUM_W'(1);
  assign w_inc = SUM_W'(w) + SUM_W'(1);

  // advance position and window ranges by one sample
  always_comb begin
    h_next        = h;
    w_next        = w;
    pr_lo_next    = pr_lo;
    prs_lo_next   = prs_lo;
    pr_hi_next    = pr_hi;
    prs_hi_next   = prs_hi;
    pslot_lo_next = pslot_lo;
    pc_lo_next    = pc_lo;
    pcs_lo_next   = pcs_lo;
    pc_hi_next    = pc_hi;
    pcs_hi_next   = pcs_hi;
    if (w_inc == w10) begin
      w_next      = '0;
      pc_lo_next  = '0;
      pcs_lo_next = '0;
      pc_hi_next  = '0;
      pcs_hi_next = '0;
      if (h_inc == h10) begin
        h_next        = '0;
        pr_lo_next    = '0;
        prs_lo_next   = '0;
        pr_hi_next    = '0;
        prs_hi_next   = '0;
        pslot_lo_next = '0;
      end else begin
        h_next = ROW_W'(h_inc);
        // oldest open window row closes on the row before
        if (SUM_W'(prs_lo) + k10 == h_inc) begin
          pr_lo_next    = pr_lo + 1'b1;
          prs_lo_next   = ROW_W'(SUM_W'(prs_lo) + s10);
          pslot_lo_next = (pslot_lo == SLOT_W'(LAST_SLOT)) ? '0 : pslot_lo + 1'b1;
        end
        // a new window row opens unless the last one already reaches the edge
        if (SUM_W'(prs_hi) + s10 == h_inc && SUM_W'(prs_hi) + k10 < h10) begin
          pr_hi_next  = pr_hi + 1'b1;
          prs_hi_next = ROW_W'(SUM_W'(prs_hi) + s10);
        end
      end
    end else begin
      w_next = COL_W'(w_inc);
      if (SUM_W'(pcs_lo) + k10 == w_inc) begin
        pc_lo_next  = pc_lo + 1'b1;
        pcs_lo_next = COL_W'(SUM_W'(pcs_lo) + s10);
      end
      if (SUM_W'(pcs_hi) + s10 == w_inc && SUM_W'(pcs_hi) + k10 < w10) begin
        pc_hi_next  = pc_hi + 1'b1;
        pcs_hi_next = COL_W'(SUM_W'(pcs_hi) + s10);
      end
    end
  end

  // position trackers
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      h        <= '0;
      w        <= '0;
      pr_lo    <= '0;
      prs_lo   <= '0;
      pr_hi    <= '0;
      prs_hi   <= '0;
      pslot_lo <= '0;
      pc_lo    <= '0;
      pcs_lo   <= '0;
      pc_hi    <= '0;
      pcs_hi   <= '0;
    end else if (cmd.start) begin
      h        <= h_next;
      w        <= w_next;
      pr_lo    <= pr_lo_next;
      prs_lo   <= prs_lo_next;
      pr_hi    <= pr_hi_next;
      prs_hi   <= prs_hi_next;
      pslot_lo <= pslot_lo_next;
      pc_lo    <= pc_lo_next;
      pcs_lo   <= pcs_lo_next;
      pc_hi    <= pc_hi_next;
      pcs_hi   <= pcs_hi_next;
    end
  end

  // window loop counters, column inner and row outer
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x      <= sample;
      lh     <= h;
      lw     <= w;
      cr     <= pr_lo;
      crs    <= prs_lo;
      cslot  <= pslot_lo;
      cr_hi  <= pr_hi;
      cc     <= pc_lo;
      ccs    <= pcs_lo;
      cc_lo  <= pc_lo;
      ccs_lo <= pcs_lo;
      cc_hi  <= pc_hi;
    end else if (cmd.upd) begin
      if (cc == cc_hi) begin
        cc    <= cc_lo;
        ccs   <= ccs_lo;
        cr    <= cr + 1'b1;
        crs   <= ROW_W'(SUM_W'(crs) + s10);
        cslot <= (cslot == SLOT_W'(LAST_SLOT)) ? '0 : cslot + 1'b1;
      end else begin
        cc  <= cc + 1'b1;
        ccs <= COL_W'(SUM_W'(ccs) + s10);
      end
    end
  end

  // accumulator address: row slot times row pitch plus column
  assign addr = AW'(cslot) * AW'(MAX_WIDTH) + AW'(cc);

  wpma_ram #(
    .WIDTH (ACC_W),
    .DEPTH (DEPTH)
  ) u_acc_ram (
    .clk     (clk),
    .we      (cmd.upd),
    .wr_addr (addr),
    .wr_data (acc_new),
    .rd_en   (cmd.rd),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  // read-modify-write of one window
  assign acc_rd = $signed(rd_data);
  assign x_ext  = ACC_W'(x);
  assign first  = (lh == crs) && (lw == ccs);

  always_comb begin
    if (first) begin
      acc_new = x_ext;
    end else if (geom.avg_mode) begin
      acc_new = acc_rd + x_ext;
    end else begin
      acc_new = (x_ext > acc_rd) ? x_ext : acc_rd;
    end
  end

  // window end: last row and last column of the clipped window
  assign crs_k     = SUM_W'(crs) + k10;
  assign ccs_k     = SUM_W'(ccs) + k10;
  assign lh_inc    = SUM_W'(lh) + SUM_W'(1);
  assign lw_inc    = SUM_W'(lw) + SUM_W'(1);
  assign row_end   = (lh_inc == crs_k) || (lh_inc == h10);
  assign col_end   = (lw_inc == ccs_k) || (lw_inc == w10);
  assign end_now   = row_end && col_end;
  assign last_grid = (crs_k >= h10) && (ccs_k >= w10);

  // capture of the finished window
  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      hit <= 1'b0;
    end else if (cmd.upd && end_now) begin
      hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && end_now) begin
      fin_val  <= acc_new;
      fin_r    <= cr;
      fin_c    <= cc;
      fin_done <= last_grid;
    end
  end

  // average scaling: sum times unsigned q1.15 reciprocal
  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      prod <= PROD_W'(fin_val) * PROD_W'($signed({1'b0, geom.recip}));
    end
  end

  // floor shift by 15 and saturate
  assign q       = prod[PROD_W-1:FRAC_SHIFT];
  assign q_ovf   = !((&q[Q_W-1:SAMPLE_W-1]) || !(|q[Q_W-1:SAMPLE_W-1]));
  assign avg_val = q_ovf ? (q[Q_W-1] ? SAT_MIN : SAT_MAX) : q[SAMPLE_W-1:0];
  assign res_val = geom.avg_mode ? avg_val : fin_val[SAMPLE_W-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_ch.pooled_value <= res_val;
      result_ch.pooled_row   <= fin_r;
      result_ch.pooled_col   <= fin_c[IDX_W-1:0];
      result_ch.plane_done   <= fin_done;
    end
  end

  assign result_ch.valid = out_valid;

  // status to the sequencer
  assign sts.last_win = (cc == cc_hi) && (cr == cr_hi);
  assign sts.hit_any  = hit || end_now;
  assign sts.hit      = hit;
  assign sts.out_free = !out_valid || result_ch.ready;

endmodule
